@@ rtl/core/ntza_pkg.sv @@
// Shared types, constants and calendar helpers for the network time zone adjust block.
package ntza_pkg;

   localparam logic [11:0] YearBase      = 12'd2000;
   localparam logic [6:0]  YearMaxInCent = 7'd99;
   localparam logic [3:0]  MonthJan      = 4'd1;
   localparam logic [3:0]  MonthFeb      = 4'd2;
   localparam logic [3:0]  MonthApr      = 4'd4;
   localparam logic [3:0]  MonthJun      = 4'd6;
   localparam logic [3:0]  MonthSep      = 4'd9;
   localparam logic [3:0]  MonthNov      = 4'd11;
   localparam logic [3:0]  MonthDec      = 4'd12;
   localparam logic [4:0]  DayFirst      = 5'd1;
   localparam logic [4:0]  DaysLong      = 5'd31;
   localparam logic [4:0]  DaysShort     = 5'd30;
   localparam logic [4:0]  DaysFebLeap   = 5'd29;
   localparam logic [4:0]  DaysFeb       = 5'd28;
   localparam logic [4:0]  HourMax       = 5'd23;
   localparam logic [4:0]  HoursHalfDay  = 5'd12;
   localparam logic [5:0]  MinuteMax     = 6'd59;
   localparam logic [10:0] MinPerHour    = 11'd60;
   localparam logic [10:0] MinPerQuarter = 11'd15;
   localparam logic [6:0]  ZoneTensScale = 7'd10;
   localparam logic signed [12:0] MinPerDay = 13'sd1440;
   // floor(t * 1093 / 2^16) == floor(t / 60) for every t below 1440
   localparam logic [21:0] RecipSixty    = 22'd1093;
   localparam int          RecipShift    = 16;

   typedef struct packed {
      logic [6:0] yy;      // year counted from 2000
      logic [3:0] month;
      logic [4:0] day;
      logic       leap;
   } date_type;

   typedef struct packed {
      logic under;         // local time fell before midnight: step back one day
      logic over;          // local time passed midnight: step forward one day
   } carry_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         MonthFeb: len = leap ? DaysFebLeap : DaysFeb;
         MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
         default: len = DaysLong;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/core/ntza_date_carry.sv @@
// Day, month and year step forward or back across midnight.
module ntza_date_carry (
   input  ntza_pkg::date_type  date,
   input  ntza_pkg::carry_type carry,
   output logic [11:0]         year,
   output logic [3:0]          month,
   output logic [4:0]          day
);
   import ntza_pkg::*;

   logic [11:0] full_year;
   logic [4:0]  cur_len;
   logic [4:0]  prev_len;

   assign full_year = YearBase + 12'(date.yy);
   assign cur_len   = month_len(date.month, date.leap);
   // January borrows from December, always 31 days
   assign prev_len  = (date.month == MonthJan) ? DaysLong
                                                : month_len(date.month - 4'd1, date.leap);

   always_comb begin
      year  = full_year;
      month = date.month;
      day   = date.day;
      // under and over never rise together; neither means no date change
      if (carry.under) begin
         if (date.day > DayFirst) begin
            day = date.day - 5'd1;
         end else begin
            day = prev_len;
            if (date.month > MonthJan) begin
               month = date.month - 4'd1;
            end else begin
               month = MonthDec;
               year  = full_year - 12'd1;
            end
         end
      end else if (carry.over) begin
         if (date.day < cur_len) begin
            day = date.day + 5'd1;
         end else begin
            day = DayFirst;
            if (date.month < MonthDec) begin
               month = date.month + 4'd1;
            end else begin
               month = MonthJan;
               year  = full_year + 12'd1;
            end
         end
      end
   end

endmodule

@@ rtl/core/network_time_zone_adjust.sv @@
// Top level: network time report plus zone octet to local date and time.
//
// Usage notes
//  - req_* channel: one beat is a network time report (two-digit year, month,
//    day, hour, minute, second, raw zone octet). A beat is taken on a rising
//    edge with req_valid high and req_stall low.
//  - rsp_* channel: one beat per request, in order: full local year, month,
//    day, hour, pm flag, minute, second. Taken when rsp_valid && !rsp_stall.
//  - csr_wr_en / csr_wr_data: the 24-hour select bit. 0 = 12-hour time with
//    pm flag, 1 = 24-hour time. Write only while the block is empty.
//  - Pipeline: four register stages: input cleanup, zone offset add and day
//    wrap, calendar carry with hour quotient (multiply by reciprocal),
//    minute remainder and 12-hour format.
//  - Throughput: one beat per cycle while rsp_stall stays low. Each stage holds
//    only while its successor is full and blocked, so bubbles close up under a stall.
//  - Receiver stall: the output stage holds its beat; stages behind it fill,
//    and req_stall rises once stage one is full and cannot move.
//  - Reset (synchronous, active high): all stage valids clear, the select
//    bit returns to 12-hour mode.
module network_time_zone_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_year_in_century,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   input  logic [7:0]  req_zone_octet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic        rsp_pm_flag,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import ntza_pkg::*;

   // ---------------- config ----------------
   logic cfg_24h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_24h_ff <= 1'b0;
      end else if (csr_wr_en) begin
         cfg_24h_ff <= csr_wr_data;
      end
   end

   // ---------------- flow control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // a stage loads when it is empty or its contents move on this edge
   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // ---------------- stage 1: clamp fields, decode zone ----------------
   logic [6:0]  yy_c;
   logic [3:0]  mon_c;
   logic        leap_c;
   logic [4:0]  len_c;
   logic [4:0]  hour_c;
   logic [5:0]  min_c;
   logic [6:0]  quarters_c;
   date_type    date1_in, date1_ff;
   logic [10:0] tod1_in, tod1_ff;       // minute of day, universal
   logic [10:0] offs1_in, offs1_ff;     // zone magnitude in minutes
   logic        neg1_ff;
   logic [5:0]  sec1_ff;

   assign yy_c  = (req_year_in_century > YearMaxInCent) ? YearMaxInCent : req_year_in_century;
   assign mon_c = (req_month_in < MonthJan) ? MonthJan :
                  (req_month_in > MonthDec) ? MonthDec : req_month_in;
   // 2000..2099: every fourth year is leap, 2000 included
   assign leap_c = (yy_c[1:0] == 2'b00);
   assign len_c  = month_len(mon_c, leap_c);

   always_comb begin
      date1_in.yy    = yy_c;
      date1_in.month = mon_c;
      date1_in.leap  = leap_c;
      date1_in.day   = (req_day_in < DayFirst) ? DayFirst :
                       (req_day_in > len_c) ? len_c : req_day_in;
   end

   assign hour_c     = (req_hour_in > HourMax) ? HourMax : req_hour_in;
   assign min_c      = (req_minute_in > MinuteMax) ? MinuteMax : req_minute_in;
   assign tod1_in    = 11'(hour_c) * MinPerHour + 11'(min_c);
   // swapped BCD; a units nibble above 9 counts at its binary value
   assign quarters_c = 7'(req_zone_octet[2:0]) * ZoneTensScale + 7'(req_zone_octet[7:4]);
   assign offs1_in   = 11'(quarters_c) * MinPerQuarter;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         date1_ff <= date1_in;
         tod1_ff  <= tod1_in;
         offs1_ff <= offs1_in;
         neg1_ff  <= req_zone_octet[3];
         sec1_ff  <= req_second_in;
      end
   end

   // ---------------- stage 2: apply offset, wrap into one day ----------------
   logic signed [12:0] t_c;
   logic [10:0]        tw2_in, tw2_ff;
   carry_type          carry2_in, carry2_ff;
   date_type           date2_ff;
   logic [5:0]         sec2_ff;

   assign t_c = neg1_ff ? ($signed({2'b00, tod1_ff}) - $signed({2'b00, offs1_ff}))
                        : ($signed({2'b00, tod1_ff}) + $signed({2'b00, offs1_ff}));

   always_comb begin
      carry2_in.under = t_c[12];
      carry2_in.over  = !t_c[12] && (t_c >= MinPerDay);
      priority if (carry2_in.under) begin
         tw2_in = 11'(t_c + MinPerDay);
      end else if (carry2_in.over) begin
         tw2_in = 11'(t_c - MinPerDay);
      end else begin
         tw2_in = t_c[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         tw2_ff    <= tw2_in;
         carry2_ff <= carry2_in;
         date2_ff  <= date1_ff;
         sec2_ff   <= sec1_ff;
      end
   end

   // ---------------- stage 3: calendar carry, hour quotient ----------------
   logic [11:0] year3_in, year3_ff;
   logic [3:0]  mon3_in, mon3_ff;
   logic [4:0]  day3_in, day3_ff;
   logic [21:0] prod_c;
   logic [4:0]  hour3_ff;
   logic [10:0] tw3_ff;
   logic [5:0]  sec3_ff;

   ntza_date_carry u_date_carry (
      .date  (date2_ff),
      .carry (carry2_ff),
      .year  (year3_in),
      .month (mon3_in),
      .day   (day3_in)
   );

   assign prod_c = 22'(tw2_ff) * RecipSixty;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         year3_ff <= year3_in;
         mon3_ff  <= mon3_in;
         day3_ff  <= day3_in;
         hour3_ff <= prod_c[RecipShift +: 5];
         tw3_ff   <= tw2_ff;
         sec3_ff  <= sec2_ff;
      end
   end

   // ---------------- stage 4: minute remainder, hour format ----------------
   logic [10:0] hour_min_c;
   logic        pm_c;
   logic [4:0]  h12_c;
   logic [4:0]  hour4_in;
   logic [5:0]  min4_in;

   assign hour_min_c = 11'(hour3_ff) * MinPerHour;
   assign min4_in    = 6'(tw3_ff - hour_min_c);
   assign pm_c       = (hour3_ff >= HoursHalfDay);

   always_comb begin
      h12_c = pm_c ? (hour3_ff - HoursHalfDay) : hour3_ff;
      // midnight and noon both read as 12
      if (h12_c == 5'd0) begin
         h12_c = HoursHalfDay;
      end
      hour4_in = cfg_24h_ff ? hour3_ff : h12_c;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_year_out   <= year3_ff;
         rsp_month_out  <= mon3_ff;
         rsp_day_out    <= day3_ff;
         rsp_hour_out   <= hour4_in;
         rsp_pm_flag    <= pm_c && !cfg_24h_ff;
         rsp_minute_out <= min4_in;
         rsp_second_out <= sec3_ff;
      end
   end

   assign rsp_valid = v4_ff;

   // ---------------- checks ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted beat did not land in stage one");

   a_no_pm_in_24h: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pm_flag && cfg_24h_ff))
      else $error("pm flag set in 24-hour mode");

   a_h12_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg_24h_ff) |-> (rsp_hour_out >= 5'd1 && rsp_hour_out <= HoursHalfDay))
      else $error("12-hour value out of range");

   a_minute_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minute_out <= MinuteMax))
      else $error("minute remainder out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_out >= MonthJan && rsp_month_out <= MonthDec
                     && rsp_day_out >= DayFirst))
      else $error("local date out of range");

endmodule

@@ dv/ntza_local_time_checker.sv @@
// Local time checker: predicts every result beat of the zone adjust block and compares it.
`timescale 1ns / 100ps
module ntza_local_time_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [6:0]  req_year_in_century,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   input  logic [7:0]  req_zone_octet,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_year_out,
   input  logic [3:0]  rsp_month_out,
   input  logic [4:0]  rsp_day_out,
   input  logic [4:0]  rsp_hour_out,
   input  logic        rsp_pm_flag,
   input  logic [5:0]  rsp_minute_out,
   input  logic [5:0]  rsp_second_out,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic        pm;
      logic [5:0]  minute;
      logic [5:0]  second;
   } local_time_t;

   local_time_t pending_local_times[$];
   local_time_t want;
   logic        fmt_24h = 1'b0;
   int          mismatch_total = 0;
   int          beats_in_flight = 0;

   assign mismatch_count = mismatch_total;
   assign outstanding    = beats_in_flight;

   function automatic bit is_leap_year(input int yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int month_days(input int mo, input int yr);
      case (mo)
         2: return is_leap_year(yr) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic local_time_t to_local_time(
         input logic [6:0] yy, input logic [3:0] mon, input logic [4:0] dom,
         input logic [4:0] hh, input logic [5:0] mm, input logic [5:0] ss,
         input logic [7:0] zone, input logic fmt24);
      int yr, mo, dy, hr, mi, quarters, offset, t;
      local_time_t lt;
      // clamp year, month, day, hour and minute into range first
      yr = (yy > 7'd99) ? 99 : int'(yy);
      yr += 2000;
      mo = int'(mon);
      if (mo < 1) mo = 1;
      if (mo > 12) mo = 12;
      dy = int'(dom);
      if (dy < 1) dy = 1;
      if (dy > month_days(mo, yr)) dy = month_days(mo, yr);
      hr = (hh > 5'd23) ? 23 : int'(hh);
      mi = (mm > 6'd59) ? 59 : int'(mm);
      // swapped digits: tens in [2:0], units in [7:4], sign in [3]
      quarters = 10 * int'(zone[2:0]) + int'(zone[7:4]);
      offset   = zone[3] ? -15 * quarters : 15 * quarters;
      t = hr * 60 + mi + offset;
      if (t < 0) begin
         t += 1440;
         if (dy > 1) begin
            dy--;
         end else begin
            if (mo > 1) begin
               mo--;
            end else begin
               mo = 12;
               yr--;
            end
            dy = month_days(mo, yr);
         end
      end else if (t >= 1440) begin
         t -= 1440;
         if (dy < month_days(mo, yr)) begin
            dy++;
         end else begin
            dy = 1;
            if (mo < 12) begin
               mo++;
            end else begin
               mo = 1;
               yr++;
            end
         end
      end
      hr = t / 60;
      mi = t % 60;
      lt.year   = 12'(yr);
      lt.month  = 4'(mo);
      lt.day    = 5'(dy);
      lt.minute = 6'(mi);
      lt.second = ss;
      if (fmt24) begin
         lt.hour = 5'(hr);
         lt.pm   = 1'b0;
      end else begin
         lt.pm   = (hr >= 12);
         lt.hour = (hr % 12 == 0) ? 5'd12 : 5'(hr % 12);
      end
      return lt;
   endfunction

   task automatic report_mismatch(input string what, input logic [11:0] got,
                                  input logic [11:0] exp_val);
      mismatch_total++;
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, exp_val);
   endtask

   task automatic check_field(input string what, input logic [11:0] got,
                              input logic [11:0] exp_val);
      if (got !== exp_val) report_mismatch(what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fmt_24h = 1'b0;
         pending_local_times.delete();
         beats_in_flight = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_local_times.size() == 0) begin
               report_mismatch("result beat with nothing expected", rsp_year_out, 12'd0);
            end else begin
               want = pending_local_times.pop_front();
               beats_in_flight--;
               check_field("year", rsp_year_out, want.year);
               check_field("month", 12'(rsp_month_out), 12'(want.month));
               check_field("day", 12'(rsp_day_out), 12'(want.day));
               check_field("hour", 12'(rsp_hour_out), 12'(want.hour));
               check_field("pm", 12'(rsp_pm_flag), 12'(want.pm));
               check_field("minute", 12'(rsp_minute_out), 12'(want.minute));
               check_field("second", 12'(rsp_second_out), 12'(want.second));
            end
         end
         if (req_valid && !req_stall) begin
            pending_local_times.push_back(to_local_time(req_year_in_century, req_month_in,
               req_day_in, req_hour_in, req_minute_in, req_second_in, req_zone_octet,
               fmt_24h));
            beats_in_flight++;
         end
         if (csr_wr_en) fmt_24h = csr_wr_data;
      end
   end

endmodule

@@ dv/tb_network_time_zone_adjust.sv @@
// Testbench top: drives time reports into the zone adjust block and gives the verdict.
`timescale 1ns / 100ps
module tb_network_time_zone_adjust;

   // hour format select values
   localparam logic TwelveHour     = 1'b0;
   localparam logic TwentyFourHour = 1'b1;

   // cycles with no beat on any port before the run is declared hung
   localparam int WatchdogLimit = 2000;
   // settle time after the last result: pipeline is 4 deep, keep margin
   localparam int DrainCycles = 8;

   typedef enum int {StallNone, StallLight, StallHeavy} stall_mode_t;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [7:0] zone;
   } report_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [6:0]  req_year_in_century = '0;
   logic [3:0]  req_month_in = '0;
   logic [4:0]  req_day_in = '0;
   logic [4:0]  req_hour_in = '0;
   logic [5:0]  req_minute_in = '0;
   logic [5:0]  req_second_in = '0;
   logic [7:0]  req_zone_octet = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic        rsp_pm_flag;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   int          mismatch_count;
   int          outstanding;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   int          stall_pick;
   stall_mode_t stall_mode = StallNone;

   network_time_zone_adjust u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_year_in_century (req_year_in_century),
      .req_month_in        (req_month_in),
      .req_day_in          (req_day_in),
      .req_hour_in         (req_hour_in),
      .req_minute_in       (req_minute_in),
      .req_second_in       (req_second_in),
      .req_zone_octet      (req_zone_octet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_year_out        (rsp_year_out),
      .rsp_month_out       (rsp_month_out),
      .rsp_day_out         (rsp_day_out),
      .rsp_hour_out        (rsp_hour_out),
      .rsp_pm_flag         (rsp_pm_flag),
      .rsp_minute_out      (rsp_minute_out),
      .rsp_second_out      (rsp_second_out),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // The checker watches all three ports on its own; the top only makes stimulus.
   ntza_local_time_checker u_local_time_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_year_in_century (req_year_in_century),
      .req_month_in        (req_month_in),
      .req_day_in          (req_day_in),
      .req_hour_in         (req_hour_in),
      .req_minute_in       (req_minute_in),
      .req_second_in       (req_second_in),
      .req_zone_octet      (req_zone_octet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_year_out        (rsp_year_out),
      .rsp_month_out       (rsp_month_out),
      .rsp_day_out         (rsp_day_out),
      .rsp_hour_out        (rsp_hour_out),
      .rsp_pm_flag         (rsp_pm_flag),
      .rsp_minute_out      (rsp_minute_out),
      .rsp_second_out      (rsp_second_out),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Hang detector: any accepted beat or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_network_time_zone_adjust failed");
         $finish;
      end
   end

   // Receiver back-pressure. A stall burst, once started, runs out regardless
   // of mode; otherwise the current mode decides how often and how long.
   // Heavy mode mixes many short bursts with rare long ones so the pipeline
   // fills completely and req_stall gets exercised.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         case (stall_mode)
            StallNone: begin
               rsp_stall <= 1'b0;
            end
            StallLight: begin
               if (stall_pick < 10) begin
                  rsp_stall <= 1'b1;
                  stall_left <= $urandom_range(0, 2);
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: begin
               if (stall_pick < 3) begin
                  rsp_stall <= 1'b1;
                  stall_left <= $urandom_range(20, 50);
               end else if (stall_pick < 40) begin
                  rsp_stall <= 1'b1;
                  stall_left <= $urandom_range(0, 3);
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   function automatic report_t make_report(
         input logic [6:0] yy, input logic [3:0] mon, input logic [4:0] dom,
         input logic [4:0] hh, input logic [5:0] mm, input logic [5:0] ss,
         input logic [7:0] zone);
      report_t r;
      r.year   = yy;
      r.month  = mon;
      r.day    = dom;
      r.hour   = hh;
      r.minute = mm;
      r.second = ss;
      r.zone   = zone;
      return r;
   endfunction

   // Random report. A quarter is raw bit noise (saturation paths, every bit
   // of every field); the rest are legal but for day and zone, pushed toward
   // month ends, year ends and midnight so the day/month/year carries fire often.
   function automatic report_t random_report();
      report_t r;
      int      pick;
      logic [2:0] tens;
      logic [3:0] units;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         r.year   = 7'($urandom_range(0, 127));
         r.month  = 4'($urandom_range(0, 15));
         r.day    = 5'($urandom_range(0, 31));
         r.hour   = 5'($urandom_range(0, 31));
         r.minute = 6'($urandom_range(0, 63));
         r.second = 6'($urandom_range(0, 63));
         r.zone   = 8'($urandom_range(0, 255));
      end else begin
         pick = $urandom_range(0, 99);
         r.year = (pick < 15) ? ($urandom_range(0, 1) ? 7'd99 : 7'd0)
                              : 7'($urandom_range(0, 99));
         pick = $urandom_range(0, 99);
         if (pick < 20) r.month = $urandom_range(0, 1) ? 4'd12 : 4'd1;
         else if (pick < 35) r.month = 4'd2;
         else r.month = 4'($urandom_range(1, 12));
         // day past the month length is clamped by the block, so 28..31 hits every end
         pick = $urandom_range(0, 99);
         if (pick < 30) r.day = 5'd1;
         else if (pick < 70) r.day = 5'($urandom_range(28, 31));
         else r.day = 5'($urandom_range(1, 31));
         pick = $urandom_range(0, 99);
         if (pick < 40) r.hour = $urandom_range(0, 1) ? 5'd23 : 5'd0;
         else r.hour = 5'($urandom_range(0, 23));
         pick = $urandom_range(0, 99);
         if (pick < 30) r.minute = $urandom_range(0, 1) ? 6'd59 : 6'd0;
         else r.minute = 6'($urandom_range(0, 59));
         r.second = 6'($urandom_range(0, 59));
         tens  = 3'($urandom_range(0, 7));
         units = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                               : 4'($urandom_range(10, 15));
         r.zone = {units, 1'($urandom_range(0, 1)), tens};
      end
      return r;
   endfunction

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One beat: present at the falling edge, hold until taken. Valid stays
   // high afterwards so back-to-back beats need no extra edge.
   task automatic send_report(input report_t r);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_year_in_century <= r.year;
      req_month_in        <= r.month;
      req_day_in          <= r.day;
      req_hour_in         <= r.hour;
      req_minute_in       <= r.minute;
      req_second_in       <= r.second;
      req_zone_octet      <= r.zone;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop sending until every expected beat has come back, then let the
   // pipeline settle.
   task automatic drain_all();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // The format bit may only change while the block is empty.
   task automatic write_format(input logic fmt);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random(input logic fmt, input stall_mode_t smode, input bit gaps_on,
                             input int beats);
      int gap;
      write_format(fmt);
      stall_mode = smode;
      for (int i = 0; i < beats; i++) begin
         send_report(random_report());
         gap = gaps_on ? pick_gap() : 0;
         if (gap > 0) idle_sender(gap);
         // occasional full stop: sender waits for the block to empty out
         if ($urandom_range(0, 149) == 0) drain_all();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed beats, 12-hour format --------------------------------
      write_format(TwelveHour);
      stall_mode = StallLight;
      // midnight, no offset: 12 AM
      send_report(make_report(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 8'h00));
      // noon under a negative zero zone: 12 PM, no change
      send_report(make_report(7'd0, 4'd1, 5'd1, 5'd12, 6'd0, 6'd0, 8'h08));
      // one hour back from new year 2000 lands in 1999
      send_report(make_report(7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 8'h48));
      // one hour on from the last minute of 2099 lands in 2100
      send_report(make_report(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 8'h40));
      // 2000 is leap: Feb 29 plus 30 minutes exactly reaches Mar 1
      send_report(make_report(7'd0, 4'd2, 5'd29, 5'd23, 6'd30, 6'd0, 8'h20));
      // 2001 not leap: Feb 28 rolls into March
      send_report(make_report(7'd1, 4'd2, 5'd28, 5'd23, 6'd45, 6'd0, 8'h10));
      // day past February length is clamped
      send_report(make_report(7'd1, 4'd2, 5'd30, 5'd12, 6'd0, 6'd0, 8'h00));
      send_report(make_report(7'd4, 4'd2, 5'd31, 5'd6, 6'd0, 6'd0, 8'h00));
      // result exactly at midnight: no borrow
      send_report(make_report(7'd5, 4'd3, 5'd1, 5'd1, 6'd0, 6'd0, 8'h48));
      // one minute before midnight: borrow into Feb 28
      send_report(make_report(7'd5, 4'd3, 5'd1, 5'd0, 6'd14, 6'd0, 8'h18));
      // leap and non-leap borrow from Mar 1
      send_report(make_report(7'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 8'h18));
      send_report(make_report(7'd1, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 8'h18));
      // largest zone count both ways (units digit 15 taken at face value)
      send_report(make_report(7'd3, 4'd6, 5'd30, 5'd10, 6'd0, 6'd0, 8'hF7));
      send_report(make_report(7'd3, 4'd7, 5'd1, 5'd5, 6'd0, 6'd0, 8'hFF));
      // non-decimal units digit
      send_report(make_report(7'd8, 4'd4, 5'd30, 5'd20, 6'd0, 6'd0, 8'hA2));
      // tens digit only, negative, from the last day of 2099
      send_report(make_report(7'd99, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 8'h0F));
      // saturation of every clamped field
      send_report(make_report(7'd127, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63, 8'h00));
      send_report(make_report(7'd100, 4'd13, 5'd31, 5'd24, 6'd60, 6'd0, 8'h00));
      send_report(make_report(7'd50, 4'd15, 5'd31, 5'd23, 6'd59, 6'd30, 8'h04));
      send_report(make_report(7'd50, 4'd4, 5'd31, 5'd11, 6'd59, 6'd1, 8'h00));
      // afternoon after a positive offset
      send_report(make_report(7'd0, 4'd10, 5'd31, 5'd12, 6'd30, 6'd0, 8'h80));
      // all zeros and all ones
      send_report(make_report(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 8'h00));
      send_report(make_report(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 8'hFF));

      // ---- random phases, alternating format and pressure ------------------
      run_random(TwentyFourHour, StallNone, 1'b0, 300);
      run_random(TwelveHour, StallHeavy, 1'b1, 450);
      run_random(TwentyFourHour, StallLight, 1'b1, 450);
      run_random(TwelveHour, StallNone, 1'b1, 250);
      run_random(TwentyFourHour, StallHeavy, 1'b0, 280);

      drain_all();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_network_time_zone_adjust passed");
      end else begin
         $display("tb_network_time_zone_adjust failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/ntza_pkg.sv
rtl/core/ntza_date_carry.sv
rtl/core/network_time_zone_adjust.sv
dv/ntza_local_time_checker.sv
dv/tb_network_time_zone_adjust.sv
